### sv/hps_pkg.sv
// ----------------------------------------------------------------------------
// hps_pkg
// Shared types and constants for the heading P steering unit: angle format,
// arctangent table for the CORDIC cells, register indexes and reset values.
// ----------------------------------------------------------------------------
package hps_pkg;

    localparam int ANG_FRAC  = 20;   // CORDIC angle: radians times 2^20
    localparam int BRG_SHIFT = 8;    // 2^20 down to 4096 counts per radian
    localparam int ZW        = 24;   // angle accumulator width
    localparam int HD_W      = 15;
    localparam int ERR_W     = 16;
    localparam int PWR_W     = 8;
    localparam int GAIN_W    = 16;
    localparam int BASE_W    = 8;
    localparam int MAX_STEPS = 20;

    localparam logic signed [ZW-1:0] HALF_PI_Q20 = 24'sd1647099;

    localparam logic signed [ZW-1:0] ATAN_Q20 [MAX_STEPS] = '{
        24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396, 24'sd65451,
        24'sd32757,  24'sd16383,  24'sd8192,   24'sd4096,   24'sd2048,
        24'sd1024,   24'sd512,    24'sd256,    24'sd128,    24'sd64,
        24'sd32,     24'sd16,     24'sd8,      24'sd4,      24'sd2
    };

    localparam logic [GAIN_W-1:0]        GAIN_RESET = 16'd256;
    localparam logic signed [BASE_W-1:0] BASE_RESET = 8'sd20;

    typedef enum logic [0:0] {
        CFG_STEER_GAIN = 1'b0,
        CFG_BASE_SPEED = 1'b1
    } t_cfg_idx;

    // Control that travels beside the data through every cell
    typedef struct packed {
        logic                   valid;
        logic                   zero;     // target equals position
        logic signed [HD_W-1:0] heading;
    } t_ctl;

endpackage

### sv/hps_pre.sv
// ----------------------------------------------------------------------------
// hps_pre
// Head cell: forms the coordinate offsets, scales them to the CORDIC format
// and folds the left half plane onto the right with a quarter turn.
// ----------------------------------------------------------------------------
module hps_pre #(
    parameter int CW = 16,
    parameter int XW = 40
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic signed [CW-1:0]        i_target_x,
    input  logic signed [CW-1:0]        i_target_y,
    input  logic signed [CW-1:0]        i_pos_x,
    input  logic signed [CW-1:0]        i_pos_y,
    input  logic signed [hps_pkg::HD_W-1:0] i_heading,
    output hps_pkg::t_ctl               o_ctl,
    output logic signed [XW-1:0]        o_x,
    output logic signed [XW-1:0]        o_y,
    output logic signed [hps_pkg::ZW-1:0] o_z
);
    import hps_pkg::*;

    logic signed [CW:0]   dx, dy;
    logic signed [XW-1:0] xe, ye;
    logic signed [XW-1:0] n_x, n_y;
    logic signed [ZW-1:0] n_z;
    t_ctl                 n_ctl;

    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    t_ctl                 r_ctl;

    always_comb begin
        dx = (CW+1)'(i_target_x) - (CW+1)'(i_pos_x);
        dy = (CW+1)'(i_target_y) - (CW+1)'(i_pos_y);
        xe = XW'(dx) <<< ANG_FRAC;
        ye = XW'(dy) <<< ANG_FRAC;
        n_x = xe;
        n_y = ye;
        n_z = '0;
        if (xe < 0) begin
            if (ye >= 0) begin
                n_x = ye;
                n_y = -xe;
                n_z = HALF_PI_Q20;
            end else begin
                n_x = -ye;
                n_y = xe;
                n_z = -HALF_PI_Q20;
            end
        end
        n_ctl.valid   = i_valid;
        n_ctl.zero    = (dx == '0) && (dy == '0);
        n_ctl.heading = i_heading;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

### sv/hps_cell.sv
// ----------------------------------------------------------------------------
// hps_cell
// One CORDIC vectoring micro-rotation: drive y towards zero by 2^-STEP and
// add the matching arctangent to the angle.
// ----------------------------------------------------------------------------
module hps_cell #(
    parameter int XW   = 40,
    parameter int STEP = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  hps_pkg::t_ctl                 i_ctl,
    input  logic signed [XW-1:0]          i_x,
    input  logic signed [XW-1:0]          i_y,
    input  logic signed [hps_pkg::ZW-1:0] i_z,
    output hps_pkg::t_ctl                 o_ctl,
    output logic signed [XW-1:0]          o_x,
    output logic signed [XW-1:0]          o_y,
    output logic signed [hps_pkg::ZW-1:0] o_z
);
    import hps_pkg::*;

    logic signed [XW-1:0] xs, ys, n_x, n_y;
    logic signed [ZW-1:0] n_z;

    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    t_ctl                 r_ctl;

    always_comb begin
        xs = i_x >>> STEP;
        ys = i_y >>> STEP;
        if (i_y > 0) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ATAN_Q20[STEP];
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ATAN_Q20[STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

### sv/hps_post.sv
// ----------------------------------------------------------------------------
// hps_post
// Tail of the chain: rounds the bearing, forms the heading error, scales it
// by the gain and produces the saturated wheel powers in the output register.
// ----------------------------------------------------------------------------
module hps_post (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  hps_pkg::t_ctl                     i_ctl,
    input  logic signed [hps_pkg::ZW-1:0]     i_z,
    input  logic [hps_pkg::GAIN_W-1:0]        i_gain,
    input  logic signed [hps_pkg::BASE_W-1:0] i_base,
    output logic                              o_valid,
    output logic signed [hps_pkg::PWR_W-1:0]  o_left_power,
    output logic signed [hps_pkg::PWR_W-1:0]  o_right_power,
    output logic signed [hps_pkg::ERR_W-1:0]  o_angle_error
);
    import hps_pkg::*;

    localparam int EW = ERR_W + 1;          // error before truncation
    localparam int MW = 2 * EW;             // error times gain
    localparam int SW = MW + 1;             // base plus product
    localparam logic signed [ZW-1:0] Z_HALF = ZW'(1) <<< (BRG_SHIFT - 1);
    localparam logic signed [SW-1:0] S_HALF = SW'(1) <<< (ANG_FRAC - 1);
    localparam logic signed [SW-1:0] P_LIM  = SW'(100);

    // round half away from zero, then clamp to the power limit
    function automatic logic signed [PWR_W-1:0] sat_power(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] q;
        if (v >= 0) q = (v + S_HALF) >>> ANG_FRAC;
        else        q = (v + S_HALF - SW'(1)) >>> ANG_FRAC;
        if (q > P_LIM)       sat_power = PWR_W'(P_LIM);
        else if (q < -P_LIM) sat_power = PWR_W'(-P_LIM);
        else                 sat_power = q[PWR_W-1:0];
    endfunction

    logic signed [ZW-1:0] zr;
    logic signed [EW-1:0] n1_err;
    logic signed [MW-1:0] n2_prod;
    logic signed [SW-1:0] base_s, sum_l, sum_r;

    logic                 r1_valid, r2_valid, r3_valid;
    logic signed [EW-1:0] r1_err, r2_err;
    logic signed [MW-1:0] r2_prod;
    logic signed [PWR_W-1:0] r3_left, r3_right;
    logic signed [ERR_W-1:0] r3_err;

    always_comb begin
        if (i_ctl.zero)     zr = '0;
        else if (i_z >= 0)  zr = (i_z + Z_HALF) >>> BRG_SHIFT;
        else                zr = (i_z + Z_HALF - ZW'(1)) >>> BRG_SHIFT;
        n1_err  = EW'($signed(zr[ERR_W-1:0])) - EW'(i_ctl.heading);
        n2_prod = MW'(r1_err) * MW'($signed({1'b0, i_gain}));
        base_s  = SW'(i_base) <<< ANG_FRAC;
        sum_l   = base_s + SW'(r2_prod);
        sum_r   = base_s - SW'(r2_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_ctl.valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_err   <= n1_err;
            r2_err   <= r1_err;
            r2_prod  <= n2_prod;
            r3_left  <= sat_power(sum_l);
            r3_right <= sat_power(sum_r);
            r3_err   <= r2_err[ERR_W-1:0];
        end
    end

    assign o_valid       = r3_valid;
    assign o_left_power  = r3_left;
    assign o_right_power = r3_right;
    assign o_angle_error = r3_err;

endmodule

### sv/heading_p_steering_unit.sv
// ----------------------------------------------------------------------------
// heading_p_steering_unit
// Proportional heading controller for a differential drive: CORDIC bearing
// to the target, heading error, and saturated left and right wheel powers.
//
//   channel   dir   width      contents
//   s_axis    in    4*CW+15    target, position, heading (padded to bytes)
//   m_axis    out   32         left and right power, angle error
//   cfg       in    1+16       steer_gain (index 0), base_speed (index 1)
//
// The chain is a head cell, one cell per CORDIC step, then error, multiply
// and output register. One item enters per cycle while the chain is not held.
// Every stage advances together whenever the output register is empty or
// being taken; while a result waits unaccepted the whole chain holds.
// Synchronous active-low reset clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module heading_p_steering_unit #(
    parameter int CORDIC_STEPS = 14,
    parameter int COORD_WIDTH  = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // target_x, target_y, pos_x, pos_y, heading, zero pad
    input  logic [((4*COORD_WIDTH+hps_pkg::HD_W+7)/8)*8-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // left_power, right_power, angle_error
    output logic [31:0]                m_axis_tdata,
    input  logic                       i_cfg_wr_en,
    input  logic [0:0]                 i_cfg_idx,
    input  logic [15:0]                i_cfg_wdata
);
    import hps_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int XW = COORD_WIDTH + ANG_FRAC + 4;

    logic                     en;
    logic [GAIN_W-1:0]        r_steer_gain;
    logic signed [BASE_W-1:0] r_base_speed;

    t_ctl                 w_ctl [CORDIC_STEPS+1];
    logic signed [XW-1:0] w_x   [CORDIC_STEPS+1];
    logic signed [XW-1:0] w_y   [CORDIC_STEPS+1];
    logic signed [ZW-1:0] w_z   [CORDIC_STEPS+1];

    logic                    out_valid;
    logic signed [PWR_W-1:0] left_power, right_power;
    logic signed [ERR_W-1:0] angle_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steer_gain <= GAIN_RESET;
            r_base_speed <= BASE_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_STEER_GAIN: r_steer_gain <= i_cfg_wdata;
                CFG_BASE_SPEED: r_base_speed <= i_cfg_wdata[BASE_W-1:0];
                default:        r_steer_gain <= r_steer_gain;
            endcase
        end
    end

    // advance the whole chain unless a result is held; refuse input in reset
    assign en            = !out_valid || m_axis_tready;
    assign s_axis_tready = en && i_rst_n;

    hps_pre #(.CW(CW), .XW(XW)) u_pre (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (s_axis_tvalid),
        .i_target_x (s_axis_tdata[CW-1:0]),
        .i_target_y (s_axis_tdata[2*CW-1:CW]),
        .i_pos_x    (s_axis_tdata[3*CW-1:2*CW]),
        .i_pos_y    (s_axis_tdata[4*CW-1:3*CW]),
        .i_heading  (s_axis_tdata[4*CW+HD_W-1:4*CW]),
        .o_ctl      (w_ctl[0]),
        .o_x        (w_x[0]),
        .o_y        (w_y[0]),
        .o_z        (w_z[0])
    );

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        hps_cell #(.XW(XW), .STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (w_ctl[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1])
        );
    end

    hps_post u_post (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_ctl         (w_ctl[CORDIC_STEPS]),
        .i_z           (w_z[CORDIC_STEPS]),
        .i_gain        (r_steer_gain),
        .i_base        (r_base_speed),
        .o_valid       (out_valid),
        .o_left_power  (left_power),
        .o_right_power (right_power),
        .o_angle_error (angle_error)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {angle_error, right_power, left_power};

endmodule

### verif/tb_heading_p_steering_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heading_p_steering_unit
// Self-checking bench for the heading P steering unit. Drives target, position
// and heading transfers with random gaps and output back-pressure, predicts
// bearing, heading error and saturated wheel powers in a scoreboard, and
// compares every output transfer field by field across several gain and base
// speed settings, the register extremes among them.
// ----------------------------------------------------------------------------
module tb_heading_p_steering_unit;

    localparam int STEPS           = 14;
    localparam int CW              = 16;
    localparam int TDATA_W         = ((4*CW + hps_pkg::HD_W + 7)/8)*8;
    localparam int LATENCY         = STEPS + 4;
    localparam int ANGLE_FRAC_BITS = 20;
    localparam int COUNT_SHIFT     = 8;          // 2^20 per radian down to 4096
    localparam longint QUARTER_TURN_Q20 = 64'sd1647099;
    localparam longint POWER_LIMIT      = 64'sd100;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int PRINT_CAP       = 40;

    localparam longint ARCTAN_Q20 [0:19] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
        1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef struct packed {
        logic signed [15:0] err;
        logic signed [7:0]  right;
        logic signed [7:0]  left;
    } t_wheel_cmd;

    class steering_scoreboard;
        logic [15:0]       gain;
        logic signed [7:0] base;
        t_wheel_cmd        wheel_cmds[$];
        int                failures;
        int                accepted;
        int                checked;

        function new();
            gain     = hps_pkg::GAIN_RESET;
            base     = hps_pkg::BASE_RESET;
            failures = 0;
            accepted = 0;
            checked  = 0;
        endfunction

        function int pending();
            return wheel_cmds.size();
        endfunction

        task report(string msg);
            if (failures < PRINT_CAP)
                $display("[%0t] steering mismatch: %s", $time, msg);
            failures++;
        endtask

        function void set_register(hps_pkg::t_cfg_idx idx, logic [15:0] val);
            case (idx)
                hps_pkg::CFG_STEER_GAIN: gain = val;
                hps_pkg::CFG_BASE_SPEED: base = val[7:0];
                default: ;
            endcase
        endfunction

        function longint round_half_away(longint v, int s);
            longint half;
            half = 64'sd1 <<< (s - 1);
            if (v >= 0)
                return (v + half) >>> s;
            return -((-v + half) >>> s);
        endfunction

        // Vectoring CORDIC; negative x is folded over by a quarter turn first
        function longint bearing_q20(longint dx, longint dy);
            longint x, y, z, t, xs, ys;
            int i;
            if (dx == 0 && dy == 0)
                return 0;
            x = dx <<< ANGLE_FRAC_BITS;
            y = dy <<< ANGLE_FRAC_BITS;
            z = 0;
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y;
                    y = -t;
                    z = QUARTER_TURN_Q20;
                end else begin
                    x = -y;
                    y = t;
                    z = -QUARTER_TURN_Q20;
                end
            end
            for (i = 0; i < STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x += ys;
                    y -= xs;
                    z += ARCTAN_Q20[i];
                end else begin
                    x -= ys;
                    y += xs;
                    z -= ARCTAN_Q20[i];
                end
            end
            return z;
        endfunction

        function longint bearing_counts(longint dx, longint dy);
            return round_half_away(bearing_q20(dx, dy), COUNT_SHIFT);
        endfunction

        function longint wheel_power(longint base_v, longint prod);
            longint p;
            p = round_half_away((base_v <<< ANGLE_FRAC_BITS) + prod, ANGLE_FRAC_BITS);
            if (p > POWER_LIMIT)
                p = POWER_LIMIT;
            else if (p < -POWER_LIMIT)
                p = -POWER_LIMIT;
            return p;
        endfunction

        task note_input(logic [TDATA_W-1:0] w);
            longint tx, ty, px, py, hd, errv, prod;
            t_wheel_cmd cmd;
            tx   = longint'($signed(w[0*CW +: CW]));
            ty   = longint'($signed(w[1*CW +: CW]));
            px   = longint'($signed(w[2*CW +: CW]));
            py   = longint'($signed(w[3*CW +: CW]));
            hd   = longint'($signed(w[4*CW +: hps_pkg::HD_W]));
            errv = bearing_counts(tx - px, ty - py) - hd;
            prod = errv * longint'(gain);
            cmd.left  = 8'(wheel_power(longint'(base), prod));
            cmd.right = 8'(wheel_power(longint'(base), -prod));
            cmd.err   = 16'(errv);
            wheel_cmds.push_back(cmd);
            accepted++;
        endtask

        task check_result(logic [31:0] d);
            t_wheel_cmd want;
            if (wheel_cmds.size() == 0) begin
                report($sformatf("result %h arrived with nothing outstanding", d));
                return;
            end
            want = wheel_cmds.pop_front();
            checked++;
            if (d[7:0] !== want.left)
                report($sformatf("left_power expected %0d got %0d",
                                 want.left, $signed(d[7:0])));
            if (d[15:8] !== want.right)
                report($sformatf("right_power expected %0d got %0d",
                                 want.right, $signed(d[15:8])));
            if (d[31:16] !== want.err)
                report($sformatf("angle_error expected %0d got %0d",
                                 want.err, $signed(d[31:16])));
        endtask
    endclass

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    // target_x, target_y, pos_x, pos_y, heading, zero pad
    logic [TDATA_W-1:0] s_axis_tdata  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // left_power, right_power, angle_error
    logic [31:0]        m_axis_tdata;
    logic               i_cfg_wr_en   = 1'b0;
    logic [0:0]         i_cfg_idx     = '0;
    logic [15:0]        i_cfg_wdata   = '0;

    steering_scoreboard sb;
    int tx_idle_pct    = 26;
    int rx_idle_pct    = 54;
    int rx_hold_left   = 0;
    int settings_count = 1;

    heading_p_steering_unit #(
        .CORDIC_STEPS (STEPS),
        .COORD_WIDTH  (CW)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Output side: random back-pressure, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata);
        end
    end

    task automatic send_item(input logic [15:0] tx, input logic [15:0] ty,
                             input logic [15:0] px, input logic [15:0] py,
                             input logic [14:0] hd);
        logic [TDATA_W-1:0] word;
        word = '0;
        word[4*CW + hps_pkg::HD_W - 1:0] = {hd, py, px, ty, tx};
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    // Drop valid and hold until every outstanding result has been taken
    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.pending() > 0);
    endtask

    task automatic write_settings(input logic [15:0] gain_v, input logic signed [7:0] base_v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= hps_pkg::CFG_STEER_GAIN;
        i_cfg_wdata <= gain_v;
        @(posedge i_clk);
        sb.set_register(hps_pkg::CFG_STEER_GAIN, gain_v);
        i_cfg_idx   <= hps_pkg::CFG_BASE_SPEED;
        i_cfg_wdata <= {{8{base_v[7]}}, base_v};
        @(posedge i_clk);
        sb.set_register(hps_pkg::CFG_BASE_SPEED, {{8{base_v[7]}}, base_v});
        i_cfg_wr_en <= 1'b0;
        settings_count++;
    endtask

    task automatic run_random(input int count);
        logic [15:0] tx, ty, px, py;
        logic [14:0] hd;
        int          kind;
        longint      brg;
        repeat (count) begin
            kind = $urandom_range(9);
            tx = 16'($urandom);
            ty = 16'($urandom);
            px = 16'($urandom);
            py = 16'($urandom);
            hd = 15'($urandom);
            case (kind)
                4, 5: begin
                    // target close to the robot: small offsets, sane heading
                    tx = px + 16'(int'($urandom_range(16)) - 8);
                    ty = py + 16'(int'($urandom_range(16)) - 8);
                    hd = 15'(int'($urandom_range(25736)) - 12868);
                end
                6: begin
                    case ($urandom_range(2))
                        0: tx = px;
                        1: ty = py;
                        default: begin
                            tx = px;
                            ty = py;
                        end
                    endcase
                end
                7, 8, 9: begin
                    // heading close to the bearing keeps powers out of saturation
                    brg = sb.bearing_counts(longint'($signed(tx)) - longint'($signed(px)),
                                            longint'($signed(ty)) - longint'($signed(py)));
                    hd = 15'(brg + longint'(int'($urandom_range(600)) - 300));
                end
                default: ;
            endcase
            send_item(tx, ty, px, py, hd);
        end
    endtask

    initial begin
        #4_000_000;
        $display("heading_p_steering_unit test failed");
        $finish;
    end

    initial begin
        int spare;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items at the reset settings
        send_item(16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'h0000);
        send_item(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 15'sd12868);
        send_item(16'h8000, 16'h0000, 16'h0000, 16'h0000, -15'sd12868);
        send_item(16'hFFFF, 16'h0005, 16'h0000, 16'h0005, 15'h3FFF);
        send_item(16'h7FFF, 16'h0000, 16'h8000, 16'h0000, 15'h4000);
        send_item(16'h8000, 16'h1234, 16'h7FFF, 16'h1234, 15'h0000);
        send_item(16'h0000, 16'h7FFF, 16'h0000, 16'h8000, 15'sd6434);
        send_item(16'h0000, 16'h8000, 16'h0000, 16'h7FFF, -15'sd6434);
        send_item(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 15'h0000);
        send_item(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 15'sd12868);
        send_item(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, -15'sd12868);
        send_item(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 15'h3FFF);
        send_item(16'h0001, 16'h0000, 16'h0000, 16'h0000, 15'h0000);
        send_item(16'h0000, 16'h0001, 16'h0000, 16'h0000, 15'h0000);
        send_item(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 15'h0000);
        send_item(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 15'h0000);
        send_item(16'h0001, 16'hFFFF, 16'h0000, 16'h0000, 15'h0000);
        send_item(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 15'h2AAA);
        send_item(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 15'h5555);
        // bearing just short of minus pi against the top heading, then the reverse
        send_item(16'hFF9C, 16'hFFFF, 16'h0000, 16'h0000, 15'sd12868);
        send_item(16'hFF9C, 16'h0000, 16'h0000, 16'h0000, 15'h4000);
        run_random(80);
        wait_all_results();

        write_settings(16'h0000, -8'sd128);
        run_random(40);
        wait_all_results();

        // Long output stall while the sender keeps offering: fill the chain
        write_settings(16'hFFFF, 8'sd127);
        rx_hold_left = HOLD_OFF_CYCLES;
        run_random(40);
        wait_all_results();

        tx_idle_pct = 54;
        rx_idle_pct = 26;
        write_settings(16'($urandom_range(8191)), 8'($urandom_range(255)));
        run_random(50);
        wait_all_results();
        run_random(50);
        wait_all_results();

        write_settings(16'h0001, -8'sd100);
        run_random(50);
        wait_all_results();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_settings(16'($urandom), 8'($urandom_range(255)));
        run_random(150);
        wait_all_results();

        write_settings(hps_pkg::GAIN_RESET, hps_pkg::BASE_RESET);
        rx_hold_left = HOLD_OFF_CYCLES / 2;
        run_random(60);

        s_axis_tvalid <= 1'b0;
        spare = 0;
        do begin
            @(posedge i_clk);
            spare++;
        end while (sb.pending() > 0 && spare < DRAIN_LIMIT);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (sb.pending() > 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));

        $display("Run: %0d steering requests in, %0d wheel commands compared, %0d failures",
                 sb.accepted, sb.checked, sb.failures);
        $display("Covered %0d gain/base settings incl. extremes, gaps, stalls and a full-chain hold",
                 settings_count);
        if (sb.failures == 0) begin
            $display("heading_p_steering_unit test passed");
        end else begin
            $display("heading_p_steering_unit test failed");
        end
        $finish;
    end

endmodule
